// File: sv/rwp_pkg.sv
`timescale 1ns / 1ps
package rwp_pkg;
    localparam int unsigned COORD_W = 18;
    localparam int unsigned DIST_W = 32;
    localparam int unsigned PEND_W = 17;
    localparam logic [COORD_W-1:0] COORD_MAX = 18'd256000;

    localparam logic [1:0] CFG_SPEED = 2'd0;
    localparam logic [1:0] CFG_PAUSE = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [4:0]          node_index;
        logic [15:0]         now;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  waypoint_x;
        logic [COORD_W-1:0]  waypoint_y;
    } t_in_item;

    typedef struct packed {
        logic [4:0]          out_node;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic                moving;
        logic                arrived;
        logic [DIST_W-1:0]   distance_total;
    } t_out_item;

    // node record held in the table
    typedef struct packed {
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]  goal_x;
        logic [COORD_W-1:0]  goal_y;
        logic                paused;
        logic [PEND_W-1:0]   pause_end;
        logic [DIST_W-1:0]   travelled;
    } t_node;

    localparam int unsigned NODE_W = $bits(t_node);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SQR,
        S_SQRT,
        S_DIVX,
        S_DIVY,
        S_WRITE,
        S_OUT
    } t_state;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction
endpackage

// File: sv/rwp_if.sv
`timescale 1ns / 1ps
interface rwp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/rwp_ram.sv
`timescale 1ns / 1ps
module rwp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/random_waypoint_node_step.sv
`timescale 1ns / 1ps
// Random waypoint step engine for a table of NODE_COUNT nodes. One input beat
// (init or step) yields exactly one output beat describing the node after the
// update; an out-of-table index yields an all-zero beat with only its index.
// Items are handled one at a time, and each item takes one of these paths:
// - an init or a paused-node step goes from the read via the load to the
//   write, and an out-of-table index from the read straight to the output;
// - a step that reaches its waypoint runs the squarer and the square root;
// - any other moving-node step also runs both divisions.
// The moving-node cost is a bit-serial squarer (one pass per axis), a
// radix-4 integer square root over the squared distance and two restoring
// bit-serial divisions over the 37-bit product, all one narrow add/subtract
// per cycle. A stalled output beat holds the next item in its final state
// until the beat is taken. The node record lives in a single RAM with a
// registered read port. Config writes take effect at once and are meant for
// idle periods only.
module random_waypoint_node_step #(
    parameter int unsigned NODE_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rwp_if.sink         s_in,
    rwp_if.source       m_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);
    import rwp_pkg::*;

    localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned RW = 19;           // reach = speed*step < 2^19
    localparam int unsigned D2W = 40;          // dx^2+dy^2 < 2^37, two bits per root step
    localparam int unsigned QW = 20;           // sqrt result width
    localparam int unsigned PW = COORD_W + RW; // mag*reach product

    // config
    logic [13:0] r_speed;
    logic [11:0] r_pause;
    logic [4:0]  r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= 14'd256;
            r_pause <= 12'd0;
            r_step  <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPEED: r_speed <= i_cfg_data;
                CFG_PAUSE: r_pause <= i_cfg_data[11:0];
                CFG_STEP:  r_step  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    t_in_item r_item;
    t_node    r_node;
    t_out_item r_out;
    logic     r_out_valid;
    logic     r_in_range;
    logic     r_arrived;

    // node table
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    t_node         ram_rdata;
    t_node         ram_wdata;

    rwp_ram #(.WIDTH(NODE_W), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_addr), .i_wdata(ram_wdata),
        .i_raddr(ram_addr), .o_rdata(ram_rdata)
    );
    assign ram_addr = AW'(r_item.node_index);

    // datapath registers
    logic [RW-1:0]        r_reach;
    logic                 r_neg_x, r_neg_y;
    logic [COORD_W-1:0]   r_mag_x, r_mag_y;
    logic [D2W-1:0]       r_acc;     // squared distance accumulator
    logic [D2W-1:0]       r_d2;
    logic [COORD_W-1:0]   r_mcand;   // squarer multiplicand
    logic [COORD_W-1:0]   r_mplier;  // squarer multiplier shift
    logic [5:0]           r_cnt;
    logic                 r_axis;
    logic [QW-1:0]        r_root;
    logic [QW+1:0]        r_rem;
    logic [PW-1:0]        r_num;     // dividend shift (product)
    logic [PW-1:0]        r_prod;
    logic [QW:0]          r_drem;
    logic [PW-1:0]        r_quo;
    logic [COORD_W-1:0]   r_step_x;

    // squarer: sum of mag*mag, one multiplier bit per cycle
    logic [D2W-1:0] sq_add;
    assign sq_add = r_acc + (r_mplier[0] ? ({{(D2W-COORD_W){1'b0}}, r_mcand} << r_cnt) : '0);

    // sqrt: two radicand bits per cycle
    logic [QW+1:0] sq_trial;
    logic [QW+1:0] sq_rem_sh;
    logic          sq_take;
    logic [QW-1:0] root_nx;
    assign sq_rem_sh = {r_rem[QW-1:0], r_d2[D2W-1 -: 2]};
    assign sq_trial  = {r_root, 2'b01};
    assign sq_take   = (sq_rem_sh >= sq_trial);
    assign root_nx   = {r_root[QW-2:0], sq_take};

    // divider: one quotient bit per cycle, divisor = r_root
    logic [QW:0] dv_sh;
    logic        dv_take;
    logic [QW:0] dv_rem;
    assign dv_sh   = {r_drem[QW-1:0], r_num[PW-1]};
    assign dv_take = (dv_sh >= {1'b0, r_root});
    assign dv_rem  = dv_take ? dv_sh - {1'b0, r_root} : dv_sh;

    logic [COORD_W-1:0] dx_raw, dy_raw;
    logic               dx_neg, dy_neg;
    assign dx_neg = ram_rdata.goal_x < ram_rdata.pos_x;
    assign dy_neg = ram_rdata.goal_y < ram_rdata.pos_y;
    assign dx_raw = dx_neg ? ram_rdata.pos_x - ram_rdata.goal_x
                           : ram_rdata.goal_x - ram_rdata.pos_x;
    assign dy_raw = dy_neg ? ram_rdata.pos_y - ram_rdata.goal_y
                           : ram_rdata.goal_y - ram_rdata.pos_y;

    logic [2*RW-1:0] reach_sq;
    assign reach_sq = r_reach * r_reach;

    logic [DIST_W:0] dist_sum_reach, dist_sum_root;
    assign dist_sum_reach = {1'b0, r_node.travelled} + {{(DIST_W+1-RW){1'b0}}, r_reach};
    assign dist_sum_root  = {1'b0, r_node.travelled} + {{(DIST_W+1-QW){1'b0}}, root_nx};

    logic [COORD_W-1:0] step_y;
    assign step_y = r_quo[COORD_W-1:0];

    // record as loaded: init overwrites it, a paused node may resume here
    t_node ld_node;
    always_comb begin
        ld_node = ram_rdata;
        if (r_item.opcode == OP_INIT) begin
            ld_node.pos_x     = clamp_coord(r_item.start_x);
            ld_node.pos_y     = clamp_coord(r_item.start_y);
            ld_node.goal_x    = clamp_coord(r_item.waypoint_x);
            ld_node.goal_y    = clamp_coord(r_item.waypoint_y);
            ld_node.paused    = 1'b0;
            ld_node.pause_end = '0;
            ld_node.travelled = '0;
        end else if (ram_rdata.paused && {1'b0, r_item.now} >= ram_rdata.pause_end) begin
            ld_node.paused = 1'b0;
            ld_node.goal_x = clamp_coord(r_item.waypoint_x);
            ld_node.goal_y = clamp_coord(r_item.waypoint_y);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_in.valid && s_in.ready) n_state = S_READ;
            S_READ:  n_state = r_in_range ? S_LOAD : S_OUT;
            S_LOAD: begin
                if (r_item.opcode == OP_INIT || ram_rdata.paused) n_state = S_WRITE;
                else n_state = S_SQR;
            end
            S_SQR:   if (r_cnt == COORD_W - 1 && r_axis) n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == QW - 1) begin
                    n_state = (r_acc <= {{(D2W-2*RW){1'b0}}, reach_sq}) ? S_WRITE : S_DIVX;
                end
            end
            S_DIVX:  if (r_cnt == PW - 1) n_state = S_DIVY;
            S_DIVY:  if (r_cnt == PW - 1) n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (!r_out_valid || m_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign s_in.ready = (r_state == S_IDLE);
    assign ram_we = (r_state == S_WRITE);
    assign ram_wdata = r_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_out_valid || m_out.ready)) r_out_valid <= 1'b1;
            else if (m_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= s_in.data;
                r_in_range <= ({{(32-5){1'b0}}, s_in.data.node_index} < NODE_COUNT);
                r_arrived <= 1'b0;
            end
            S_LOAD: begin
                r_node  <= ld_node;
                r_reach <= RW'(r_speed * r_step);
                r_neg_x <= dx_neg;
                r_neg_y <= dy_neg;
                r_mag_x <= dx_raw;
                r_mag_y <= dy_raw;
                r_mcand <= dx_raw;
                r_mplier <= dx_raw;
                r_acc   <= '0;
                r_cnt   <= '0;
                r_axis  <= 1'b0;
            end
            S_SQR: begin
                r_acc <= sq_add;
                if (r_cnt == COORD_W - 1) begin
                    r_cnt <= '0;
                    r_axis <= 1'b1;
                    r_mcand <= r_mag_y;
                    r_mplier <= r_mag_y;
                    if (r_axis) begin
                        r_d2 <= sq_add;
                        r_root <= '0;
                        r_rem <= '0;
                    end
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            S_SQRT: begin
                r_d2 <= r_d2 << 2;
                r_rem  <= sq_take ? sq_rem_sh - sq_trial : sq_rem_sh;
                r_root <= root_nx;
                if (r_cnt == QW - 1) begin
                    r_cnt <= '0;
                    r_num <= PW'(r_mag_x) * PW'(r_reach);
                    r_prod <= PW'(r_mag_y) * PW'(r_reach);
                    r_drem <= '0;
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
                if (n_state == S_WRITE) begin
                    // within reach: snap to the waypoint, distance is the full root
                    r_node.pos_x <= r_node.goal_x;
                    r_node.pos_y <= r_node.goal_y;
                    r_node.paused <= 1'b1;
                    r_node.pause_end <= PEND_W'({1'b0, r_item.now} + {5'd0, r_pause});
                    r_node.travelled <= dist_sum_root[DIST_W] ? '1 : dist_sum_root[DIST_W-1:0];
                    r_arrived <= 1'b1;
                end
            end
            S_DIVX, S_DIVY: begin
                r_quo <= {r_quo[PW-2:0], dv_take};
                if (r_cnt == PW - 1 && r_state == S_DIVX) begin
                    r_num <= r_prod;
                    r_drem <= '0;
                end else begin
                    r_num <= r_num << 1;
                    r_drem <= dv_rem;
                end
                if (r_cnt == PW - 1) begin
                    r_cnt <= '0;
                    if (r_state == S_DIVX) begin
                        r_step_x <= {r_quo[COORD_W-2:0], dv_take};
                    end
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            default: ;
        endcase
        if (r_state == S_DIVY && r_cnt == PW - 1) begin
            r_node.pos_x <= r_neg_x ? r_node.pos_x - r_step_x : r_node.pos_x + r_step_x;
            r_node.pos_y <= r_neg_y ? r_node.pos_y - {step_y[COORD_W-2:0], dv_take}
                                    : r_node.pos_y + {step_y[COORD_W-2:0], dv_take};
            r_node.travelled <= dist_sum_reach[DIST_W] ? '1 : dist_sum_reach[DIST_W-1:0];
        end
        if (r_state == S_OUT && (!r_out_valid || m_out.ready)) begin
            r_out.out_node <= r_item.node_index;
            if (r_in_range) begin
                r_out.pos_x <= r_node.pos_x;
                r_out.pos_y <= r_node.pos_y;
                r_out.moving <= !r_node.paused;
                r_out.arrived <= r_arrived;
                r_out.distance_total <= r_node.travelled;
            end else begin
                r_out.pos_x <= '0;
                r_out.pos_y <= '0;
                r_out.moving <= 1'b0;
                r_out.arrived <= 1'b0;
                r_out.distance_total <= '0;
            end
        end
    end

    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_out;

    // assertions
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready) |=> (r_state == S_READ))
        else $error("accept did not start read");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_in_range)
        else $error("write to out-of-range node");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQRT |-> r_cnt < QW)
        else $error("sqrt counter overrun");
endmodule
